// ----- src/cblw_pkg.sv -----
package cblw_pkg;

    // window geometry
    localparam int WINDOW_DEPTH = 5;
    localparam int COUNT_WIDTH  = 24;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W        = COUNT_WIDTH + $clog2(WINDOW_DEPTH + 1);

    // configuration
    localparam int               BAUD_W     = 20;
    localparam logic [BAUD_W-1:0] BAUD_RESET = BAUD_W'(500000);

    // field widths
    localparam int DLC_W  = 4;
    localparam int LOAD_W = 8;

    // frame bit counts without stuffing
    localparam int FRAME_BITS_W  = 8;
    localparam logic [FRAME_BITS_W-1:0] STD_FRAME_BITS = FRAME_BITS_W'(47);
    localparam logic [FRAME_BITS_W-1:0] EXT_FRAME_BITS = FRAME_BITS_W'(67);

    // divider operands
    localparam int PCT_SCALE = 100;
    localparam int NUM_W     = SUM_W + 7;
    localparam int DIV_W     = BAUD_W + $clog2(WINDOW_DEPTH + 1);
    localparam int STEP_W    = $clog2(NUM_W);

    // request opcodes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_START,
        ST_DIV,
        ST_HOLD
    } state_t;

endpackage

// ----- src/cblw_if.sv -----
interface cblw_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [cblw_pkg::DLC_W-1:0]    dlc;
    logic                          extended_id;

    modport source (output valid, output op, output dlc, output extended_id, input ready);
    modport sink   (input valid, input op, input dlc, input extended_id, output ready);
endinterface

interface cblw_res_if;
    logic                          valid;
    logic                          ready;
    logic [cblw_pkg::LOAD_W-1:0]   load_percent;

    modport source (output valid, output load_percent, input ready);
    modport sink   (input valid, input load_percent, output ready);
endinterface

// ----- src/cblw_window.sv -----
module cblw_window (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              update,
    input  logic                              op,
    input  logic [cblw_pkg::DLC_W-1:0]        dlc,
    input  logic                              extended_id,
    output logic [cblw_pkg::SUM_W-1:0]        window_sum
);

    logic [cblw_pkg::COUNT_WIDTH-1:0] interval_bits_reg;
    logic [cblw_pkg::COUNT_WIDTH-1:0] interval_bits_next;
    logic [cblw_pkg::COUNT_WIDTH-1:0] counts_reg [cblw_pkg::WINDOW_DEPTH];
    logic [cblw_pkg::SLOT_W-1:0]      slot_reg;
    logic [cblw_pkg::SLOT_W-1:0]      slot_next;
    logic [cblw_pkg::SUM_W-1:0]       sum_reg;
    logic [cblw_pkg::SUM_W-1:0]       sum_next;
    logic [cblw_pkg::FRAME_BITS_W-1:0] frame_bits;
    logic [cblw_pkg::COUNT_WIDTH:0]   acc_sum;

    // frame length: header by id type plus eight bits per dlc code
    assign frame_bits = (extended_id ? cblw_pkg::EXT_FRAME_BITS : cblw_pkg::STD_FRAME_BITS)
                      + {1'b0, dlc, 3'b000};

    assign acc_sum = {1'b0, interval_bits_reg}
                   + (cblw_pkg::COUNT_WIDTH + 1)'(frame_bits);

    always_comb
    begin
        interval_bits_next = interval_bits_reg;
        slot_next          = slot_reg;
        sum_next           = sum_reg;
        if (op == cblw_pkg::OP_FRAME)
        begin
            // saturate at all ones
            interval_bits_next = acc_sum[cblw_pkg::COUNT_WIDTH]
                               ? {cblw_pkg::COUNT_WIDTH{1'b1}}
                               : acc_sum[cblw_pkg::COUNT_WIDTH-1:0];
        end
        else
        begin
            interval_bits_next = '0;
            sum_next = sum_reg
                     - cblw_pkg::SUM_W'(counts_reg[slot_reg])
                     + cblw_pkg::SUM_W'(interval_bits_reg);
            slot_next = (slot_reg == cblw_pkg::SLOT_W'(cblw_pkg::WINDOW_DEPTH - 1))
                      ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_bits_reg <= '0;
            slot_reg          <= '0;
            sum_reg           <= '0;
            for (int i = 0; i < cblw_pkg::WINDOW_DEPTH; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (update)
        begin
            interval_bits_reg <= interval_bits_next;
            slot_reg          <= slot_next;
            sum_reg           <= sum_next;
            if (op == cblw_pkg::OP_TICK)
            begin
                counts_reg[slot_reg] <= interval_bits_reg;
            end
        end
    end

    assign window_sum = sum_reg;

endmodule

// ----- src/cblw_div.sv -----
module cblw_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [cblw_pkg::NUM_W-1:0]        numerator,
    input  logic [cblw_pkg::DIV_W-1:0]        divisor,
    output logic                              done,
    output logic [cblw_pkg::LOAD_W-1:0]       quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [cblw_pkg::STEP_W-1:0]       step_reg;
    logic [cblw_pkg::NUM_W-1:0]        num_reg;
    logic [cblw_pkg::DIV_W-1:0]        div_reg;
    logic [cblw_pkg::DIV_W:0]          rem_reg;
    logic [cblw_pkg::LOAD_W-1:0]       q_reg;
    logic                              ovf_reg;
    logic [cblw_pkg::DIV_W:0]          rem_shift;
    logic                              q_bit;
    logic [cblw_pkg::DIV_W:0]          rem_next;

    // one restoring step: shift in next numerator bit, trial subtract
    assign rem_shift = {rem_reg[cblw_pkg::DIV_W-1:0], num_reg[cblw_pkg::NUM_W-1]};
    assign q_bit     = rem_shift >= {1'b0, div_reg};
    assign rem_next  = q_bit ? rem_shift - {1'b0, div_reg} : rem_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= cblw_pkg::STEP_W'(cblw_pkg::NUM_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numerator;
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[cblw_pkg::NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[cblw_pkg::LOAD_W-2:0], q_bit};
            // any quotient bit above the result width means saturation
            ovf_reg <= ovf_reg | q_reg[cblw_pkg::LOAD_W-1];
        end
    end

    // zero divisor makes every trial succeed, so it saturates too
    assign done     = done_reg;
    assign quotient = ovf_reg ? {cblw_pkg::LOAD_W{1'b1}} : q_reg;

endmodule

// ----- src/can_bus_load_window.sv -----
// can bus load monitor over a sliding window of measurement intervals
//
// req channel (valid/ready): op selects a frame request (adds 47 or 67 bits
// plus eight per dlc code to the interval count, saturating) or a tick
// request (closes the interval into the next window slot, clears the count)
// res channel (valid/ready): one load_percent per request,
// floor(window sum * 100 / (window depth * baud rate)), saturated at 255
// baud_wr_en / baud_wr_data: write the baud rate, only while idle
//
// sequence: the window updates at the accept edge, then the operands are
// registered, the divider is started, the bit-serial restoring divider works
// one quotient bit per cycle, and the quotient loads the output register;
// one request is in flight at a time and ready returns the cycle after the
// result loads, so a new request is not taken before the last one's result
// has loaded
// reset: interval count, window slots, slot pointer and sum clear to zero,
// baud rate returns to 500000, no result pending
// stall: a finished result waits in the output register; the next request
// is still taken, and its result waits in the divider until res is free
module can_bus_load_window (
    input  logic                          clk,
    input  logic                          rst_n,
    cblw_req_if.sink                      req,
    cblw_res_if.source                    res,
    input  logic                          baud_wr_en,
    input  logic [cblw_pkg::BAUD_W-1:0]   baud_wr_data
);

    cblw_pkg::state_t state_reg;
    cblw_pkg::state_t state_next;

    logic [cblw_pkg::BAUD_W-1:0]  baud_reg;
    logic [cblw_pkg::NUM_W-1:0]   num_reg;
    logic [cblw_pkg::DIV_W-1:0]   div_reg;
    logic [cblw_pkg::LOAD_W-1:0]  out_data_reg;
    logic                         out_valid_reg;
    logic [cblw_pkg::SUM_W-1:0]   window_sum;
    logic                         req_take;
    logic                         out_free;
    logic                         out_load;
    logic                         div_start;
    logic                         div_done;
    logic [cblw_pkg::LOAD_W-1:0]  div_quotient;

    assign req.ready = (state_reg == cblw_pkg::ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || res.ready;

    // window state is updated at the accept edge
    cblw_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (req_take),
        .op          (req.op),
        .dlc         (req.dlc),
        .extended_id (req.extended_id),
        .window_sum  (window_sum)
    );

    // single bit-serial divider, used for every request
    cblw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (num_reg),
        .divisor   (div_reg),
        .done      (div_done),
        .quotient  (div_quotient)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            cblw_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = cblw_pkg::ST_LOAD;
                end
            end
            cblw_pkg::ST_LOAD:
            begin
                state_next = cblw_pkg::ST_START;
            end
            cblw_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = cblw_pkg::ST_DIV;
            end
            cblw_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = cblw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = cblw_pkg::ST_HOLD;
                    end
                end
            end
            cblw_pkg::ST_HOLD:
            begin
                // quotient stays put in the divider until the output frees up
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = cblw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cblw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cblw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // baud rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baud_reg <= cblw_pkg::BAUD_RESET;
        end
        else if (baud_wr_en)
        begin
            baud_reg <= baud_wr_data;
        end
    end

    // divider operands: sum * 100 over depth * baud
    // sum * 100 formed as sum * 64 + sum * 32 + sum * 4
    always_ff @(posedge clk)
    begin
        if (state_reg == cblw_pkg::ST_LOAD)
        begin
            num_reg <= (cblw_pkg::NUM_W'(window_sum) << 6)
                     + (cblw_pkg::NUM_W'(window_sum) << 5)
                     + (cblw_pkg::NUM_W'(window_sum) << 2);
            div_reg <= cblw_pkg::DIV_W'(baud_reg) * cblw_pkg::DIV_W'(cblw_pkg::WINDOW_DEPTH);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= div_quotient;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.load_percent = out_data_reg;

endmodule
